// ===== hw/rtl/csfw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfw_pkg
// Types and codes shared by the counting semaphore with a FIFO of waiters.
// ----------------------------------------------------------------------------
package csfw_pkg;

    localparam int TOKEN_BITS      = 31;
    localparam int THREAD_ID_BITS  = 8;
    localparam int COUNT_BITS      = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    typedef logic [TOKEN_BITS-1:0]     token_t;
    typedef logic [THREAD_ID_BITS-1:0] thread_t;
    typedef logic [COUNT_BITS-1:0]     count_t;

    localparam token_t TOKEN_MAX = '1;

    localparam logic [1:0] ACT_WAIT   = 2'd0;
    localparam logic [1:0] ACT_SIGNAL = 2'd1;
    localparam logic [1:0] ACT_CLOSE  = 2'd2;

    typedef enum logic [2:0] {
        STAT_GRANTED  = 3'd0,
        STAT_BLOCKED  = 3'd1,
        STAT_CLOSED   = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_SIGNALED = 3'd4,
        STAT_RELEASED = 3'd5,
        STAT_WOKEN    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_SIGNAL,
        OP_CLOSE
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [1:0] action;
        thread_t    thread_id;
        count_t     count;
    } req_t;

    typedef struct packed {
        status_t status;
        thread_t thread_out;
        logic    last;
    } rsp_t;

    typedef struct packed {
        op_t     op;
        thread_t thread_id;
        count_t  count;
    } cmd_t;

endpackage

// ===== hw/rtl/csfw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfw_front
// Request intake: decodes each beat into a command and holds it in a
// two-entry queue ahead of the engine. Unused action codes are dropped.
// ----------------------------------------------------------------------------
module csfw_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  csfw_pkg::req_t req,
    output logic          cmd_valid,
    output csfw_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import csfw_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       accept;
    logic       keep;
    logic       push;
    op_t        op;

    assign req_stall = (cnt_reg == 2'd2);
    assign accept    = req_valid && !req_stall;
    assign push      = accept && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        keep = 1'b1;
        op   = OP_WAIT;
        unique case (req.action)
            ACT_WAIT:   op = OP_WAIT;
            ACT_SIGNAL: op = OP_SIGNAL;
            ACT_CLOSE:  op = OP_CLOSE;
            default:    keep = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{op: op, thread_id: req.thread_id, count: req.count};
        end
    end

endmodule

// ===== hw/rtl/csfw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfw_engine
// Semaphore engine: token count, closed flag and waiter queue. Executes one
// command at a time, releasing or waking one waiter per cycle while the result
// port is not stalled, and drives a registered result port.
// ----------------------------------------------------------------------------
module csfw_engine #(
    parameter int QUEUE_DEPTH = csfw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  csfw_pkg::token_t cfg_data,
    input  logic            cmd_valid,
    input  csfw_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output csfw_pkg::rsp_t  rsp
);
    import csfw_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
    localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

    state_t           state_reg;
    state_t           state_next;
    token_t           token_reg;
    token_t           token_next;
    logic             closed_reg;
    logic             closed_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             out_valid_reg;
    rsp_t             out_reg;

    thread_t          mem_thread [QUEUE_DEPTH];
    count_t           mem_tokens [QUEUE_DEPTH];
    thread_t          rd_thread_reg;
    count_t           rd_tokens_reg;

    logic             emit_ok;
    logic             emit;
    rsp_t             emit_data;
    logic             push;
    logic             start_drain;
    logic [TOKEN_BITS:0] sum;
    logic             fits_cmd;
    logic             fits_head;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] tail_inc;

    assign emit_ok   = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign sum       = {1'b0, token_reg} + (TOKEN_BITS + 1)'(cmd.count);
    assign fits_cmd  = (token_reg >= TOKEN_BITS'(cmd.count));
    assign fits_head = (token_reg >= TOKEN_BITS'(rd_tokens_reg));
    assign head_inc  = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;

    assign start_drain = cmd_valid && emit_ok
                         && (((cmd.op == OP_SIGNAL) && !closed_reg)
                             || ((cmd.op == OP_CLOSE) && (occ_reg != '0)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_drain)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cmd_pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        token_next  = token_reg;
        closed_next = closed_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        push        = 1'b0;
        emit        = 1'b0;
        emit_data   = '{status: STAT_GRANTED, thread_out: cmd.thread_id, last: 1'b1};
        cmd_pop     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && emit_ok)
                begin
                    unique case (cmd.op)
                        OP_WAIT:
                        begin
                            emit    = 1'b1;
                            cmd_pop = 1'b1;
                            priority if (closed_reg)
                            begin
                                emit_data.status = STAT_CLOSED;
                            end
                            else if (fits_cmd)
                            begin
                                emit_data.status = STAT_GRANTED;
                                token_next       = token_reg - TOKEN_BITS'(cmd.count);
                            end
                            else if (occ_reg == OCC_FULL)
                            begin
                                emit_data.status = STAT_FULL;
                            end
                            else
                            begin
                                emit_data.status = STAT_BLOCKED;
                                push             = 1'b1;
                                tail_next        = tail_inc;
                                occ_next         = occ_reg + 1'b1;
                            end
                        end
                        OP_SIGNAL:
                        begin
                            if (closed_reg)
                            begin
                                emit             = 1'b1;
                                cmd_pop          = 1'b1;
                                emit_data.status = STAT_CLOSED;
                            end
                            else
                            begin
                                token_next = sum[TOKEN_BITS] ? TOKEN_MAX : sum[TOKEN_BITS-1:0];
                            end
                        end
                        OP_CLOSE:
                        begin
                            closed_next = 1'b1;
                            if (occ_reg == '0)
                            begin
                                cmd_pop = 1'b1;
                            end
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    if (cmd.op == OP_CLOSE)
                    begin
                        emit_data = '{status: STAT_WOKEN, thread_out: rd_thread_reg,
                                      last: (occ_reg == OCC_ONE)};
                        head_next = head_inc;
                        occ_next  = occ_reg - 1'b1;
                        cmd_pop   = (occ_reg == OCC_ONE);
                    end
                    else if ((occ_reg != '0) && fits_head)
                    begin
                        emit_data  = '{status: STAT_RELEASED, thread_out: rd_thread_reg,
                                       last: 1'b0};
                        token_next = token_reg - TOKEN_BITS'(rd_tokens_reg);
                        head_next  = head_inc;
                        occ_next   = occ_reg - 1'b1;
                    end
                    else
                    begin
                        emit_data.status = STAT_SIGNALED;
                        cmd_pop          = 1'b1;
                    end
                end
            end
            default: cmd_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            token_reg     <= '0;
            closed_reg    <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            token_reg  <= cfg_we ? cfg_data : token_next;
            closed_reg <= closed_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= emit_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_thread[tail_reg] <= cmd.thread_id;
            mem_tokens[tail_reg] <= cmd.count;
        end
        rd_thread_reg <= mem_thread[head_next];
        rd_tokens_reg <= mem_tokens[head_next];
    end

endmodule

// ===== hw/rtl/counting_semaphore_fifo_waiters.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a FIFO queue of waiting threads.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue and are executed one at a time by
// the engine; each result is registered at the end of the engine cycle that
// produces it. An open signal adds its count, then releases waiters from the
// head while their counts fit; a close sets the closed flag and wakes every
// queued waiter. The waiter memory, written at the tail and read at the queue
// head, sustains one waiter per cycle while the result port is not stalled. A
// cfg_we write reloads the token count and must be issued only while the
// block is idle. The waiter memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters #(
    parameter int QUEUE_DEPTH = csfw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  csfw_pkg::token_t cfg_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  csfw_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output csfw_pkg::rsp_t   rsp
);
    import csfw_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    csfw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    csfw_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
